FILE: hw/rtl/mlr_pkg.sv
// Package: widths, defaults and request codes for the midpoint line rasterizer.
package mlr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int PIX_BITS       = 12;
	localparam int COLOR_BITS     = 32;

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

endpackage

FILE: hw/rtl/midpoint_line_rasterizer_top.sv
// Top level: midpoint line rasterizer with registered request and pixel stages.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  request | req_valid/req_ready  | req_type start_x start_y end_x end_y line_color
//  pixel   | pix_valid/pix_ready  | pixel_x pixel_y pixel_color last_pixel
//
// One request per cycle is taken unless a held pixel stalls the request stage; it sits in the
// request register, and its pixel then goes to the output register (setup/step logic between).
// The decision add and compare picks the step increment and the minor-axis move.
// arst_n clears the line state and both valid flags.
// A pixel held in the output register stalls the request stage, which then
// drops req_ready; this holds for every request, including one that emits nothing.
module midpoint_line_rasterizer_top
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  req_type,
	input  logic [PIX_BITS-1:0]   start_x,
	input  logic [PIX_BITS-1:0]   start_y,
	input  logic [PIX_BITS-1:0]   end_x,
	input  logic [PIX_BITS-1:0]   end_y,
	input  logic [COLOR_BITS-1:0] line_color,
	output logic                  pix_valid,
	input  logic                  pix_ready,
	output logic [PIX_BITS-1:0]   pixel_x,
	output logic [PIX_BITS-1:0]   pixel_y,
	output logic [COLOR_BITS-1:0] pixel_color,
	output logic                  last_pixel
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 3;

	// request register
	logic                  valid_s1;
	logic                  req_type_s1;
	logic [CB-1:0]         x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COLOR_BITS-1:0] color_s1;

	// line state
	logic                  line_active_q;
	logic                  axes_swapped_q;
	logic                  minor_falls_q;
	logic [CB-1:0]         major_pos_q;
	logic [CB-1:0]         major_end_q;
	logic [CB-1:0]         minor_pos_q;
	logic signed [DW-1:0]  decision_q;
	logic signed [DW-1:0]  step_lower_inc_q;
	logic signed [DW-1:0]  step_upper_inc_q;
	logic [COLOR_BITS-1:0] held_color_q;

	// pixel register
	logic                  pix_valid_q;
	logic [PIX_BITS-1:0]   pixel_x_q, pixel_y_q;
	logic [COLOR_BITS-1:0] pixel_color_q;
	logic                  last_pixel_q;

	logic proc_fire;

	assign proc_fire = valid_s1 && (!pix_valid_q || pix_ready);
	assign req_ready = !valid_s1 || proc_fire;

	// input masking to coordinate width
	logic [PIX_BITS+CB-1:0] sx_ext, sy_ext, ex_ext, ey_ext;
	assign sx_ext = {{CB{1'b0}}, start_x};
	assign sy_ext = {{CB{1'b0}}, start_y};
	assign ex_ext = {{CB{1'b0}}, end_x};
	assign ey_ext = {{CB{1'b0}}, end_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_type_s1 <= req_type;
			x0_s1       <= sx_ext[CB-1:0];
			y0_s1       <= sy_ext[CB-1:0];
			x1_s1       <= ex_ext[CB-1:0];
			y1_s1       <= ey_ext[CB-1:0];
			color_s1    <= line_color;
		end
	end

	// start setup
	logic [CB-1:0]        adx, ady;
	logic                 steep;
	logic [CB-1:0]        pa0, pb0, pa1, pb1;
	logic [CB-1:0]        a0, b0, a1, b1;
	logic signed [DW-1:0] a0e, b0e, a1e, b1e, dx, dy;
	logic signed [DW-1:0] su_dec, su_lower, su_upper;
	logic                 su_falls;

	always_comb begin
		adx   = (x1_s1 > x0_s1) ? x1_s1 - x0_s1 : x0_s1 - x1_s1;
		ady   = (y1_s1 > y0_s1) ? y1_s1 - y0_s1 : y0_s1 - y1_s1;
		steep = ady > adx;
		pa0   = steep ? y0_s1 : x0_s1;
		pb0   = steep ? x0_s1 : y0_s1;
		pa1   = steep ? y1_s1 : x1_s1;
		pb1   = steep ? x1_s1 : y1_s1;
		if (pa0 > pa1) begin
			a0 = pa1; b0 = pb1; a1 = pa0; b1 = pb0;
		end else begin
			a0 = pa0; b0 = pb0; a1 = pa1; b1 = pb1;
		end
		a0e = {3'b000, a0};
		b0e = {3'b000, b0};
		a1e = {3'b000, a1};
		b1e = {3'b000, b1};
		dx  = a1e - a0e;
		dy  = b1e - b0e;
		su_falls = dy < 0;
		if (!su_falls) begin
			su_dec   = dx - (dy <<< 1);
			su_lower = -(dy <<< 1);
			su_upper = (dx - dy) <<< 1;
		end else begin
			su_dec   = -dx - (dy <<< 1);
			su_lower = -((dx + dy) <<< 1);
			su_upper = -(dy <<< 1);
		end
	end

	// next state and pixel
	logic                  n_active, n_swapped, n_falls, emit;
	logic [CB-1:0]         n_major, n_end, n_minor;
	logic signed [DW-1:0]  n_dec, n_lower, n_upper;
	logic [COLOR_BITS-1:0] n_color;
	logic [CB-1:0]         px, py;
	logic                  n_last;
	logic [PIX_BITS+CB-1:0] px_ext, py_ext;

	always_comb begin
		n_active  = line_active_q;
		n_swapped = axes_swapped_q;
		n_falls   = minor_falls_q;
		n_major   = major_pos_q;
		n_end     = major_end_q;
		n_minor   = minor_pos_q;
		n_dec     = decision_q;
		n_lower   = step_lower_inc_q;
		n_upper   = step_upper_inc_q;
		n_color   = held_color_q;
		emit      = 1'b0;
		unique case (req_type_s1)
			REQ_START: begin
				n_swapped = steep;
				n_falls   = su_falls;
				n_major   = a0;
				n_end     = a1;
				n_minor   = b0;
				n_dec     = su_dec;
				n_lower   = su_lower;
				n_upper   = su_upper;
				n_color   = color_s1;
				emit      = 1'b1;
			end
			REQ_ADVANCE: begin
				priority if (!line_active_q) begin
					emit = 1'b0;
				end else if (major_pos_q >= major_end_q) begin
					n_active = 1'b0;
				end else begin
					if (decision_q > 0) begin
						n_dec = decision_q + step_lower_inc_q;
						if (minor_falls_q) begin
							n_minor = minor_pos_q - 1'b1;
						end
					end else begin
						n_dec = decision_q + step_upper_inc_q;
						if (!minor_falls_q) begin
							n_minor = minor_pos_q + 1'b1;
						end
					end
					n_major = major_pos_q + 1'b1;
					emit    = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		n_last = n_major == n_end;
		if (emit) begin
			n_active = !n_last;
		end
		px     = n_swapped ? n_minor : n_major;
		py     = n_swapped ? n_major : n_minor;
		px_ext = {{PIX_BITS{1'b0}}, px};
		py_ext = {{PIX_BITS{1'b0}}, py};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q    <= 1'b0;
			axes_swapped_q   <= 1'b0;
			minor_falls_q    <= 1'b0;
			major_pos_q      <= '0;
			major_end_q      <= '0;
			minor_pos_q      <= '0;
			decision_q       <= '0;
			step_lower_inc_q <= '0;
			step_upper_inc_q <= '0;
			held_color_q     <= '0;
			pix_valid_q      <= 1'b0;
		end else begin
			if (proc_fire) begin
				line_active_q    <= n_active;
				axes_swapped_q   <= n_swapped;
				minor_falls_q    <= n_falls;
				major_pos_q      <= n_major;
				major_end_q      <= n_end;
				minor_pos_q      <= n_minor;
				decision_q       <= n_dec;
				step_lower_inc_q <= n_lower;
				step_upper_inc_q <= n_upper;
				held_color_q     <= n_color;
				pix_valid_q      <= emit;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire && emit) begin
			pixel_x_q     <= px_ext[PIX_BITS-1:0];
			pixel_y_q     <= py_ext[PIX_BITS-1:0];
			pixel_color_q <= n_color;
			last_pixel_q  <= n_last;
		end
	end

	assign pix_valid   = pix_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last_pixel  = last_pixel_q;

endmodule

FILE: test/tb.sv
// Testbench for midpoint_line_rasterizer_top: directed and random lines checked against a predictor.
module tb
	import mlr_pkg::*;
;

	localparam int CYCLE_LIMIT = 500000;
	localparam int COORD_MAX   = (1 << PIX_BITS) - 1;

	typedef struct {
		logic [PIX_BITS-1:0]   x;
		logic [PIX_BITS-1:0]   y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	logic                  req_type;
	logic [PIX_BITS-1:0]   start_x;
	logic [PIX_BITS-1:0]   start_y;
	logic [PIX_BITS-1:0]   end_x;
	logic [PIX_BITS-1:0]   end_y;
	logic [COLOR_BITS-1:0] line_color;
	logic                  pix_valid;
	logic                  pix_ready;
	logic [PIX_BITS-1:0]   pixel_x;
	logic [PIX_BITS-1:0]   pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	midpoint_line_rasterizer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_color  (line_color),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	pixel_t pixel_q[$];
	int     error_count;
	int     cycle_count;
	int     pixel_requests;
	bit     idle_on;

	// line tracker
	logic                  ln_active;
	logic                  ln_steep;
	logic                  ln_falls;
	logic [PIX_BITS-1:0]   maj_pos;
	logic [PIX_BITS-1:0]   maj_end;
	logic [PIX_BITS-1:0]   min_pos;
	int                    dec;
	int                    inc_lo;
	int                    inc_hi;
	logic [COLOR_BITS-1:0] ln_color;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 100)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	// returns 1 when the request yields a pixel, queued as expected
	function automatic bit raster_predict(input logic typ, input logic [PIX_BITS-1:0] sx,
			input logic [PIX_BITS-1:0] sy, input logic [PIX_BITS-1:0] ex,
			input logic [PIX_BITS-1:0] ey, input logic [COLOR_BITS-1:0] col);
		int x0, y0, x1, y1, adx, ady, a0, b0, a1, b1, dx, dy, t;
		pixel_t px;
		if (typ == REQ_START) begin
			x0 = int'(sx);
			y0 = int'(sy);
			x1 = int'(ex);
			y1 = int'(ey);
			adx = (x1 > x0) ? x1 - x0 : x0 - x1;
			ady = (y1 > y0) ? y1 - y0 : y0 - y1;
			ln_steep = (ady > adx);
			if (ln_steep) begin
				a0 = y0; b0 = x0; a1 = y1; b1 = x1;
			end else begin
				a0 = x0; b0 = y0; a1 = x1; b1 = y1;
			end
			if (a0 > a1) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			dx = a1 - a0;
			dy = b1 - b0;
			if (dy >= 0) begin
				ln_falls = 1'b0;
				dec      = dx - 2 * dy;
				inc_lo   = -2 * dy;
				inc_hi   = 2 * (dx - dy);
			end else begin
				ln_falls = 1'b1;
				dec      = -dx - 2 * dy;
				inc_lo   = -2 * (dx + dy);
				inc_hi   = -2 * dy;
			end
			maj_pos   = PIX_BITS'(a0);
			maj_end   = PIX_BITS'(a1);
			min_pos   = PIX_BITS'(b0);
			ln_color  = col;
			ln_active = 1'b1;
		end else begin
			if (!ln_active)
				return 1'b0;
			if (maj_pos >= maj_end) begin
				ln_active = 1'b0;
				return 1'b0;
			end
			if (dec > 0) begin
				dec += inc_lo;
				if (ln_falls)
					min_pos = min_pos - 1'b1;
			end else begin
				dec += inc_hi;
				if (!ln_falls)
					min_pos = min_pos + 1'b1;
			end
			maj_pos = maj_pos + 1'b1;
		end
		px.x     = ln_steep ? min_pos : maj_pos;
		px.y     = ln_steep ? maj_pos : min_pos;
		px.color = ln_color;
		px.last  = (maj_pos == maj_end);
		if (px.last)
			ln_active = 1'b0;
		pixel_q.push_back(px);
		return 1'b1;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input logic typ, input logic [PIX_BITS-1:0] sx,
			input logic [PIX_BITS-1:0] sy, input logic [PIX_BITS-1:0] ex,
			input logic [PIX_BITS-1:0] ey, input logic [COLOR_BITS-1:0] col);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= typ;
		start_x    <= sx;
		start_y    <= sy;
		end_x      <= ex;
		end_y      <= ey;
		line_color <= col;
		do @(posedge clk); while (!req_ready);
		if (raster_predict(typ, sx, sy, ex, ey, col))
			pixel_requests++;
		@(negedge clk);
	endtask

	task automatic send_advance();
		send_req(REQ_ADVANCE, PIX_BITS'($urandom), PIX_BITS'($urandom), PIX_BITS'($urandom),
			PIX_BITS'($urandom), $urandom);
	endtask

	task automatic send_line(input int sx, input int sy, input int ex, input int ey,
			input logic [COLOR_BITS-1:0] col, input int advances);
		send_req(REQ_START, PIX_BITS'(sx), PIX_BITS'(sy), PIX_BITS'(ex), PIX_BITS'(ey), col);
		repeat (advances) send_advance();
	endtask

	// pixel side
	initial begin
		pix_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				pix_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			pix_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && pix_valid && pix_ready) begin
			if (pixel_q.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x, pixel_y));
			end else begin
				exp_px = pixel_q.pop_front();
				if (pixel_x !== exp_px.x)
					report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, exp_px.x));
				if (pixel_y !== exp_px.y)
					report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, exp_px.y));
				if (pixel_color !== exp_px.color)
					report_mismatch($sformatf("pixel_color %h, want %h", pixel_color,
						exp_px.color));
				if (last_pixel !== exp_px.last)
					report_mismatch($sformatf("last_pixel %b, want %b", last_pixel,
						exp_px.last));
			end
		end
	end

	task automatic test_idle_advance();
		send_advance();
		send_advance();
	endtask

	task automatic test_zero_length();
		send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 1);
		send_line(0, 0, 0, 0, 32'h0, 0);
	endtask

	task automatic test_shallow_rising();
		send_line(0, 0, 5, 2, 32'hA5A5_5A5A, 5);
	endtask

	task automatic test_steep_falling_reversed();
		send_line(0, COORD_MAX, 2, COORD_MAX - 4, 32'h1234_5678, 4);
	endtask

	task automatic test_abandon();
		send_line(COORD_MAX, 0, 0, 0, 32'hDEAD_BEEF, 2);
		send_line(10, 10, 12, 13, 32'h0F0F_F0F0, 4);
	endtask

	task automatic test_random_lines(input int target, input bit with_idle);
		int base, mode, sx, sy, ex, ey, ddx, ddy, ext, n;
		base    = pixel_requests;
		idle_on = with_idle;
		while (pixel_requests - base < target) begin
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				repeat ($urandom_range(1, 3)) send_advance();
			end else if (mode == 1) begin
				send_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), $urandom,
					$urandom_range(0, 6));
			end else begin
				sx  = $urandom_range(0, COORD_MAX);
				sy  = $urandom_range(0, COORD_MAX);
				ddx = int'($urandom_range(0, 24)) - 12;
				ddy = int'($urandom_range(0, 24)) - 12;
				ex  = sx + ddx;
				ey  = sy + ddy;
				if (ex < 0 || ex > COORD_MAX)
					ex = sx - ddx;
				if (ey < 0 || ey > COORD_MAX)
					ey = sy - ddy;
				ext = (ddx < 0 ? -ddx : ddx);
				if ((ddy < 0 ? -ddy : ddy) > ext)
					ext = (ddy < 0 ? -ddy : ddy);
				if ($urandom_range(0, 4) == 0)
					n = $urandom_range(0, ext);
				else
					n = ext + $urandom_range(0, 2);
				send_line(sx, sy, ex, ey, $urandom, n);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_type   = REQ_START;
		start_x    = '0;
		start_y    = '0;
		end_x      = '0;
		end_y      = '0;
		line_color = '0;
		idle_on    = 1'b1;
		ln_active  = 1'b0;
		ln_steep   = 1'b0;
		ln_falls   = 1'b0;
		maj_pos    = '0;
		maj_end    = '0;
		min_pos    = '0;
		dec        = 0;
		inc_lo     = 0;
		inc_hi     = 0;
		ln_color   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_advance();
		test_zero_length();
		test_shallow_rising();
		test_steep_falling_reversed();
		test_abandon();
		test_random_lines(540, 1'b1);
		test_random_lines(180, 1'b0);
		test_random_lines(500, 1'b1);
		test_random_lines(180, 1'b0);

		req_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/mlr_pkg.sv
hw/rtl/midpoint_line_rasterizer_top.sv
test/tb.sv
